>>> sv/gfov_pkg.sv
`default_nettype none
package gfov_pkg;
  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_VIEW  = 2'd2,
    REQ_READ  = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ZERO,
    ST_SCAN,
    ST_CLR,
    ST_WSETUP,
    ST_WREAD,
    ST_WCHECK,
    ST_MARK,
    ST_RREAD,
    ST_RDONE,
    ST_OUT
  } state_t;

  localparam logic [4:0] RADIUS_RESET = 5'd15;
  localparam logic [1:0] ADDR_RADIUS = 2'd0;
  localparam int REQ_W = 2;
  localparam int ROW_W = 6;
  localparam int COL_W = 7;
  localparam int RAD_W = 5;
endpackage
`default_nettype wire

>>> sv/gfov_if.sv
`default_nettype none
interface gfov_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [5:0] row;
  logic [6:0] col;
  logic       transparent_in;
  modport source (output valid, req_type, row, col, transparent_in, input ready);
  modport sink (input valid, req_type, row, col, transparent_in, output ready);
endinterface

interface gfov_rsp_if;
  logic valid;
  logic ready;
  logic cell_visible;
  logic cell_seen;
  logic cell_transparent;
  modport source (output valid, cell_visible, cell_seen, cell_transparent, input ready);
  modport sink (input valid, cell_visible, cell_seen, cell_transparent, output ready);
endinterface
`default_nettype wire

>>> sv/gfov_ram.sv
`default_nettype none
module gfov_ram #(
  parameter int AW = 13,
  parameter int DW = 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);
  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> sv/grid_field_of_view_los.sv
// Grid field-of-view engine.
// Requests arrive on req (valid/ready); each produces exactly one transfer on rsp.
// Request kinds: write a cell's transparency, clear visible bits in the window
// around a position, compute the field of view from a position, read a cell.
// Only reads return live bits; other responses are all zero.
// Map state lives in two memories: transparency (1 bit) and view (visible, seen).
// A clear read-modify-writes the view memory one cell at a time, keeping seen.
// A write's response is offered the cycle after acceptance; a read passes RREAD and RDONE first.
// Clear visits (2R)^2 window cells: an interior cell passes SCAN and CLR, others only SCAN.
// A view request scans (2R)^2 window cells; a candidate cell is set up in SCAN,
// passes WSETUP, WREAD and WCHECK per Bresenham step it tests (step, memory read,
// check), then WSETUP and MARK for the final step and the mark.
// One request is in flight at a time; the next is taken the cycle after the
// response transfer.
// Reset: an initial pass zeroes every view entry, one per cycle
// (2**(RB+CB) entries, 8192 at the default size), while req.ready stays low.
// The radius register resets to 15 and may be written through the APB port
// whenever the block is idle.
// When the receiver stalls, the response is held and no new request is taken.
`default_nettype none
module grid_field_of_view_los
  import gfov_pkg::*;
#(
  parameter int MAP_ROWS = 64,
  parameter int MAP_COLS = 128
) (
  input  wire logic        clk,
  input  wire logic        rst,
  gfov_req_if.sink         req,
  gfov_rsp_if.source       rsp,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  localparam int RB = $clog2(MAP_ROWS);
  localparam int CB = $clog2(MAP_COLS);
  localparam int AW = RB + CB;
  localparam int CW = 12; // signed coordinate width

  logic [RAD_W-1:0] radius;
  assign pready = 1'b1;
  assign prdata = {27'd0, radius};
  always_ff @(posedge clk) begin
    if (rst) radius <= RADIUS_RESET;
    else if (psel && penable && pwrite && paddr == ADDR_RADIUS) radius <= pwdata[RAD_W-1:0];
  end

  state_t state, state_next;
  req_t kind;
  logic signed [CW-1:0] vr, vc, tr, tc, wr, wc, t, adr, adc, sr, sc;
  logic signed [CW-1:0] rend, cend;
  logic [5:0] k;
  logic xmaj;
  logic [AW-1:0] zaddr;
  logic o_vis, o_seen, o_tr;

  // memories
  logic          t_we, v_we;
  logic [AW-1:0] t_waddr, t_raddr, v_waddr, v_raddr;
  logic          t_wdata, t_rdata;
  logic [1:0]    v_wdata, v_rdata;

  gfov_ram #(.AW(AW), .DW(1)) u_tmem (.clk, .we(t_we), .waddr(t_waddr),
    .wdata(t_wdata), .raddr(t_raddr), .rdata(t_rdata));
  gfov_ram #(.AW(AW), .DW(2)) u_vmem (.clk, .we(v_we), .waddr(v_waddr),
    .wdata(v_wdata), .raddr(v_raddr), .rdata(v_rdata));

  function automatic logic in_map(input logic signed [CW-1:0] r, c);
    return r >= 0 && r < MAP_ROWS && c >= 0 && c < MAP_COLS;
  endfunction
  function automatic logic inner(input logic signed [CW-1:0] r, c);
    return r > 0 && r < MAP_ROWS - 1 && c > 0 && c < MAP_COLS - 1;
  endfunction
  function automatic logic [AW-1:0] addr_of(input logic signed [CW-1:0] r, c);
    return {r[RB-1:0], c[CB-1:0]};
  endfunction

  logic signed [CW-1:0] dr, dc, ddr, ddc, abs_dr, abs_dc;
  logic [23:0] dist2, rad2;
  assign dr = tr - vr;
  assign dc = tc - vc;
  assign dist2 = 24'(dr * dr) + 24'(dc * dc);
  assign rad2  = 24'({7'd0, radius} * {7'd0, radius});
  assign ddr = vr - tr;
  assign ddc = vc - tc;
  assign abs_dr = (ddr < 0) ? -ddr : ddr;
  assign abs_dc = (ddc < 0) ? -ddc : ddc;

  // next target in row-major order across the window
  logic signed [CW-1:0] tr_adv, tc_adv;
  always_comb begin
    tr_adv = tr;
    tc_adv = tc + CW'(1);
    if (tc_adv >= cend) begin
      tc_adv = vc - $signed(CW'(radius));
      tr_adv = tr + CW'(1);
    end
  end

  // one Bresenham step, computed from current walk state
  logic signed [CW-1:0] nr, nc, nt;
  always_comb begin
    nr = wr; nc = wc; nt = t;
    if (xmaj) begin
      if (t >= 0) begin nr = wr + sr; nt = t - (adc <<< 1); end
      nc = wc + sc;
      nt = nt + (adr <<< 1);
    end else begin
      if (t >= 0) begin nc = wc + sc; nt = t - (adr <<< 1); end
      nr = wr + sr;
      nt = nt + (adc <<< 1);
    end
  end

  assign req.ready = (state == ST_IDLE);
  assign rsp.valid = (state == ST_OUT);
  assign rsp.cell_visible = o_vis;
  assign rsp.cell_seen = o_seen;
  assign rsp.cell_transparent = o_tr;

  always_comb begin
    state_next = state;
    case (state)
      ST_ZERO:   if (zaddr == {AW{1'b1}}) state_next = ST_IDLE;
      ST_IDLE:   if (req.valid) begin
        case (req_t'(req.req_type))
          REQ_WRITE: state_next = ST_OUT;
          REQ_READ:  state_next = ST_RREAD;
          default:   state_next = ST_SCAN;
        endcase
      end
      ST_SCAN:   state_next = (tr >= rend) ? ST_OUT : ST_SCAN;
      ST_CLR:    state_next = ST_SCAN;
      ST_WSETUP: state_next = ST_WREAD;
      ST_WREAD:  state_next = ST_WCHECK;
      ST_WCHECK: state_next = ST_WSETUP;
      ST_MARK:   state_next = ST_SCAN;
      ST_RREAD:  state_next = ST_RDONE;
      ST_RDONE:  state_next = ST_OUT;
      ST_OUT:    if (rsp.ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
    // walk-related refinements
    if (state == ST_SCAN && tr < rend) begin
      if (kind == REQ_VIEW && dist2 < rad2 && inner(tr, tc) && !(tr == vr && tc == vc))
        state_next = ST_WSETUP;
      else if (kind == REQ_CLEAR && inner(tr, tc))
        state_next = ST_CLR;
    end
    if (state == ST_WSETUP) begin
      if (k == 6'd0 || (nr == vr && nc == vc)) state_next = ST_MARK;
      else if (!in_map(nr, nc)) state_next = ST_SCAN;
    end
    if (state == ST_WCHECK && !t_rdata) state_next = ST_SCAN;
  end

  // memory port control
  always_comb begin
    t_we = 1'b0; t_waddr = addr_of(CW'(req.row), CW'(req.col));
    t_wdata = req.transparent_in;
    t_raddr = addr_of(wr, wc);
    v_we = 1'b0; v_waddr = addr_of(tr, tc); v_wdata = 2'b11;
    v_raddr = addr_of(vr, vc);
    case (state)
      ST_ZERO: begin v_we = 1'b1; v_waddr = zaddr; v_wdata = 2'b00; end
      ST_IDLE: begin
        t_we = req.valid && req.req_type == REQ_WRITE && in_map(CW'(req.row), CW'(req.col));
        if (req.valid && req.req_type == REQ_VIEW && in_map(CW'(req.row), CW'(req.col))) begin
          v_we = 1'b1; v_waddr = addr_of(CW'(req.row), CW'(req.col));
        end
      end
      // fetch the target's view word so a clear can keep its seen bit
      ST_SCAN: v_raddr = addr_of(tr, tc);
      ST_CLR: begin v_we = 1'b1; v_wdata = {v_rdata[1], 1'b0}; end
      ST_WSETUP: t_raddr = addr_of(nr, nc);
      ST_MARK: v_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ZERO;
      zaddr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_ZERO) zaddr <= zaddr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: if (req.valid) begin
        kind <= req_t'(req.req_type);
        vr <= CW'(req.row); vc <= CW'(req.col);
        tr <= CW'(req.row) - CW'(radius); tc <= CW'(req.col) - CW'(radius);
        rend <= CW'(req.row) + CW'(radius); cend <= CW'(req.col) + CW'(radius);
        o_vis <= 1'b0; o_seen <= 1'b0; o_tr <= 1'b0;
        if (req.req_type == REQ_READ) begin
          wr <= CW'(req.row); wc <= CW'(req.col);
        end
      end
      ST_SCAN: begin
        // prepare walk for current target; advance target only while staying in SCAN
        wr <= tr; wc <= tc;
        adr <= abs_dr;
        adc <= abs_dc;
        sr <= (ddr < 0) ? -CW'(1) : CW'(1);
        sc <= (ddc < 0) ? -CW'(1) : CW'(1);
        xmaj <= abs_dc > abs_dr;
        if (abs_dc > abs_dr) begin
          t <= (abs_dr <<< 1) - abs_dc;
          k <= abs_dc[5:0];
        end else begin
          t <= (abs_dc <<< 1) - abs_dr;
          k <= abs_dr[5:0];
        end
        if (state_next == ST_SCAN) begin
          tr <= tr_adv; tc <= tc_adv;
        end
      end
      ST_WSETUP: begin
        wr <= nr; wc <= nc; t <= nt; k <= k - 6'd1;
      end
      ST_MARK, ST_WCHECK, ST_CLR: if (state_next == ST_SCAN) begin
        tr <= tr_adv; tc <= tc_adv;
      end
      ST_RDONE: if (in_map(wr, wc)) begin
        o_vis <= v_rdata[0]; o_seen <= v_rdata[1]; o_tr <= t_rdata;
      end
      default: ;
    endcase
    // walk setup in SCAN leaves target unchanged; skip-out paths from WSETUP advance
    if (state == ST_WSETUP && state_next == ST_SCAN) begin
      tr <= tr_adv; tc <= tc_adv;
    end
  end
endmodule
`default_nettype wire

>>> tb/grid_field_of_view_los_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module grid_field_of_view_los_tb;
  import gfov_pkg::*;

  localparam int ROWS = 64;
  localparam int COLS = 128;

  // Transparency is only read inside this block of cells and at a few single
  // cells written up front; views of radius 3 stay centred on it
  localparam int AREA_R0 = 30;
  localparam int AREA_C0 = 61;
  localparam int AREA_N  = 6;

  typedef struct {
    req_t       kind;
    logic [5:0] row;
    logic [6:0] col;
    logic       tin;
  } request_t;

  typedef struct {
    logic vis;
    logic seen;
    logic trans;
  } cell_bits_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  gfov_req_if req_ch ();
  gfov_rsp_if rsp_ch ();

  grid_field_of_view_los dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the map and the radius register
  bit        map_trans [ROWS*COLS];
  bit        map_vis   [ROWS*COLS];
  bit        map_seen  [ROWS*COLS];
  int        radius = RADIUS_RESET;

  request_t   pending_reqs [$];
  cell_bits_t cells_due [$];
  request_t   cur_req;
  int         send_idle = 0;
  int         recv_stall = 0;
  bit         no_idle = 0;
  int         fails = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Hold every input at a known value from time zero
  initial begin
    rst = 1;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    req_ch.valid = 0;
    req_ch.req_type = REQ_WRITE;
    req_ch.row = '0;
    req_ch.col = '0;
    req_ch.transparent_in = 0;
    rsp_ch.ready = 0;
    repeat (5) @(posedge clk);
    rst <= 0;
  end

  // Mostly short gaps, now and then a long one; none at all in burst phases
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (no_idle || p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic bit see_through(int r, int c);
    if (r < 0 || r >= ROWS || c < 0 || c >= COLS) return 0;
    return map_trans[r*COLS + c];
  endfunction

  function automatic bit on_interior(int r, int c);
    return r > 0 && r < ROWS - 1 && c > 0 && c < COLS - 1;
  endfunction

  // Step from the target towards the viewer; the target and viewer cells are not tested
  function automatic bit line_clear(int vr, int vc, int tr, int tc);
    int dc, dr, adc, adr, sc, sr, r, c, t;
    dc = vc - tc;
    dr = vr - tr;
    adc = dc < 0 ? -dc : dc;
    adr = dr < 0 ? -dr : dr;
    sc = dc < 0 ? -1 : 1;
    sr = dr < 0 ? -1 : 1;
    r = tr;
    c = tc;
    if (adc > adr) begin
      t = 2*adr - adc;
      for (int k = 0; k < adc; k++) begin
        if (t >= 0) begin
          r += sr;
          t -= 2*adc;
        end
        c += sc;
        t += 2*adr;
        if (r == vr && c == vc) return 1;
        if (!see_through(r, c)) return 0;
      end
    end else begin
      t = 2*adc - adr;
      for (int k = 0; k < adr; k++) begin
        if (t >= 0) begin
          c += sc;
          t -= 2*adr;
        end
        r += sr;
        t += 2*adc;
        if (r == vr && c == vc) return 1;
        if (!see_through(r, c)) return 0;
      end
    end
    return 1;
  endfunction

  function automatic void wipe_window(int vr, int vc);
    for (int r = vr - radius; r < vr + radius; r++)
      for (int c = vc - radius; c < vc + radius; c++)
        if (on_interior(r, c)) map_vis[r*COLS + c] = 0;
  endfunction

  function automatic void light_window(int vr, int vc);
    int dr, dc;
    map_vis[vr*COLS + vc] = 1;
    map_seen[vr*COLS + vc] = 1;
    for (int r = vr - radius; r < vr + radius; r++) begin
      for (int c = vc - radius; c < vc + radius; c++) begin
        dr = r - vr;
        dc = c - vc;
        if (dr*dr + dc*dc < radius*radius && on_interior(r, c) &&
            !(r == vr && c == vc) && line_clear(vr, vc, r, c)) begin
          map_vis[r*COLS + c] = 1;
          map_seen[r*COLS + c] = 1;
        end
      end
    end
  endfunction

  function automatic void predict_cell(request_t q);
    cell_bits_t res;
    int idx;
    idx = int'(q.row)*COLS + int'(q.col);
    res = '{vis: 0, seen: 0, trans: 0};
    case (q.kind)
      REQ_WRITE: map_trans[idx] = q.tin;
      REQ_CLEAR: wipe_window(q.row, q.col);
      REQ_VIEW:  light_window(q.row, q.col);
      default: begin
        res.vis = map_vis[idx];
        res.seen = map_seen[idx];
        res.trans = map_trans[idx];
      end
    endcase
    cells_due.push_back(res);
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: take the next pending request once the current one is
  // transferred and any gap has run out
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    logic nxt_valid;
    if (rst) begin
      req_ch.valid <= 0;
    end else begin
      nxt_valid = req_ch.valid;
      if (req_ch.valid && req_ch.ready) begin
        predict_cell(cur_req);
        nxt_valid = 0;
      end
      if (!nxt_valid) begin
        if (send_idle > 0) begin
          send_idle--;
        end else if (pending_reqs.size() > 0) begin
          cur_req = pending_reqs.pop_front();
          req_ch.req_type <= cur_req.kind;
          req_ch.row <= cur_req.row;
          req_ch.col <= cur_req.col;
          req_ch.transparent_in <= cur_req.tin;
          nxt_valid = 1;
          send_idle = pick_gap();
        end
      end
      req_ch.valid <= nxt_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // Response monitor: check each transfer against the oldest prediction,
  // and stall the response side at random
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cell_bits_t exp_bits;
    if (rst) begin
      rsp_ch.ready <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (cells_due.size() == 0) begin
          $error("response with no request outstanding");
          fails++;
        end else begin
          exp_bits = cells_due.pop_front();
          if (rsp_ch.cell_visible !== exp_bits.vis) begin
            $error("cell_visible: expected %0d, got %0d", exp_bits.vis, rsp_ch.cell_visible);
            fails++;
          end
          if (rsp_ch.cell_seen !== exp_bits.seen) begin
            $error("cell_seen: expected %0d, got %0d", exp_bits.seen, rsp_ch.cell_seen);
            fails++;
          end
          if (rsp_ch.cell_transparent !== exp_bits.trans) begin
            $error("cell_transparent: expected %0d, got %0d", exp_bits.trans,
                   rsp_ch.cell_transparent);
            fails++;
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        rsp_ch.ready <= 0;
      end else begin
        rsp_ch.ready <= 1;
        recv_stall = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic void queue_req(req_t k, int r, int c, bit t);
    request_t q;
    q.kind = k;
    q.row = r[5:0];
    q.col = c[6:0];
    q.tin = t;
    pending_reqs.push_back(q);
  endfunction

  // Reads and writes stay in the written block; views of radius 2 or less
  // test no transparency and may sit anywhere
  function automatic void queue_random(int rad);
    int p;
    p = $urandom_range(0, 99);
    if (p < 45)
      queue_req(REQ_READ, AREA_R0 + $urandom_range(0, AREA_N-1),
                AREA_C0 + $urandom_range(0, AREA_N-1), $urandom_range(0, 1));
    else if (p < 65)
      queue_req(REQ_WRITE, AREA_R0 + $urandom_range(0, AREA_N-1),
                AREA_C0 + $urandom_range(0, AREA_N-1), $urandom_range(0, 3) != 0);
    else if (p < 85) begin
      if (rad > 2)
        queue_req(REQ_VIEW, 32 + $urandom_range(0, 1), 63 + $urandom_range(0, 1), 0);
      else
        queue_req(REQ_VIEW, $urandom_range(0, ROWS-1), $urandom_range(0, COLS-1), 0);
    end else
      queue_req(REQ_CLEAR, 32 + $urandom_range(0, 4) - 2,
                63 + $urandom_range(0, 4) - 2, $urandom_range(0, 1));
  endfunction

  // Hold the sender until every request has been answered
  task automatic drain();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || req_ch.valid || cells_due.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_radius(int value);
    drain();
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= '0;
    pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    radius = value;
    @(posedge clk);
  endtask

  task automatic random_phase(int rad, int count, bit burst);
    set_radius(rad);
    no_idle = burst;
    for (int i = 0; i < count; i++) queue_random(rad);
  endtask

  initial begin
    @(negedge rst);
    // Write every cell whose transparency is ever read, mostly see-through
    for (int r = 0; r < AREA_N; r++)
      for (int c = 0; c < AREA_N; c++)
        queue_req(REQ_WRITE, AREA_R0 + r, AREA_C0 + c, $urandom_range(0, 3) != 0);
    queue_req(REQ_WRITE, 0, 0, 1);
    queue_req(REQ_WRITE, 1, 1, 0);
    queue_req(REQ_WRITE, ROWS-1, COLS-1, 1);
    queue_req(REQ_WRITE, ROWS-2, COLS-2, 1);
    queue_req(REQ_WRITE, 10, 10, 0);
    queue_req(REQ_WRITE, 10, 11, 1);

    // Reset radius: reads and a clear only
    queue_req(REQ_READ, 0, 0, 1);
    queue_req(REQ_READ, ROWS-1, COLS-1, 0);
    queue_req(REQ_CLEAR, 32, 63, 0);

    // Radius 3 around the centre of the block, one clear and one opaque cell
    set_radius(3);
    queue_req(REQ_WRITE, 31, 63, 1);
    queue_req(REQ_WRITE, 33, 63, 0);
    queue_req(REQ_VIEW, 32, 63, 0);
    queue_req(REQ_READ, 32, 63, 0);
    queue_req(REQ_READ, 30, 63, 0);
    queue_req(REQ_READ, 34, 63, 0);
    queue_req(REQ_READ, 32, 65, 0);

    // Corner viewers: only border and near cells in the window
    set_radius(2);
    queue_req(REQ_VIEW, 0, 0, 0);
    queue_req(REQ_READ, 0, 0, 0);
    queue_req(REQ_READ, 1, 1, 0);
    queue_req(REQ_VIEW, ROWS-1, COLS-1, 0);
    queue_req(REQ_READ, ROWS-1, COLS-1, 0);
    queue_req(REQ_READ, ROWS-2, COLS-2, 0);

    // Largest radius: a clear drops visible bits and keeps seen ones
    set_radius(31);
    queue_req(REQ_CLEAR, 20, 80, 0);
    queue_req(REQ_READ, 32, 63, 0);
    queue_req(REQ_READ, 1, 1, 0);

    // Radius zero: a view marks only the viewer, a clear does nothing
    set_radius(0);
    queue_req(REQ_VIEW, 10, 10, 0);
    queue_req(REQ_READ, 10, 10, 0);
    queue_req(REQ_READ, 10, 11, 0);
    queue_req(REQ_CLEAR, 10, 10, 0);
    queue_req(REQ_READ, 10, 10, 0);

    random_phase(1, 10, 0);
    random_phase(3, 12, 1);
    random_phase(2, 10, 0);
    random_phase(3, 10, 0);

    drain();
    repeat (50) @(posedge clk);
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire
